// ===== rtl/wsfr_pkg.sv =====
`timescale 1ns / 1ps

package wsfr_pkg;

   localparam int OP_W     = 2;
   localparam int BYTE_W   = 8;
   localparam int KIND_W   = 3;
   localparam int MLEN_W   = 16;
   localparam int LIMIT_W  = 17;
   localparam int FLEN_W   = 64;

   localparam logic [OP_W-1:0] OP_BYTE  = 2'd0;
   localparam logic [OP_W-1:0] OP_OPEN  = 2'd1;
   localparam logic [OP_W-1:0] OP_ERROR = 2'd2;

   localparam logic [KIND_W-1:0] KIND_PAYLOAD   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_EMPTY     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SEND_PONG = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PONG_RX   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DISCONN   = 3'd4;

   localparam logic [3:0] OPC_TEXT   = 4'h1;
   localparam logic [3:0] OPC_BINARY = 4'h2;
   localparam logic [3:0] OPC_CLOSE  = 4'h8;
   localparam logic [3:0] OPC_PING   = 4'h9;
   localparam logic [3:0] OPC_PONG   = 4'hA;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;

   localparam logic [LIMIT_W-1:0] SKIP_LIMIT_RESET = 17'd8192;
   localparam logic [LIMIT_W-1:0] LIMIT_CAP        = 17'd65536;

   typedef enum logic [5:0] {
      PH_HDR0    = 6'b000001,
      PH_HDR1    = 6'b000010,
      PH_EXT     = 6'b000100,
      PH_KEY     = 6'b001000,
      PH_DELIVER = 6'b010000,
      PH_DISCARD = 6'b100000
   } phase_type;

   typedef struct packed {
      phase_type         phase;
      logic [3:0]        opcode;
      logic              mask_on;
      logic [3:0]        ext_left;
      logic [31:0]       mask_key;
      logic [1:0]        mask_pos;
      logic [FLEN_W-1:0] remaining;
      logic [FLEN_W-1:0] payload_len;
   } pars_type;

   localparam pars_type PARS_RESET = '{
      phase:       PH_HDR0,
      opcode:      4'h0,
      mask_on:     1'b0,
      ext_left:    4'h0,
      mask_key:    32'h0,
      mask_pos:    2'd0,
      remaining:   64'd0,
      payload_len: 64'd0
   };

endpackage

// ===== rtl/wsfr_if.sv =====
`timescale 1ns / 1ps

interface wsfr_req_if
   import wsfr_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output op, output rx_byte, input ready);
   modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface wsfr_rsp_if
   import wsfr_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic              msg_type;
   logic [BYTE_W-1:0] data_byte;
   logic [MLEN_W-1:0] msg_length;
   logic              last;

   modport source (output valid, output kind, output msg_type, output data_byte,
                   output msg_length, output last, input ready);
   modport sink   (input valid, input kind, input msg_type, input data_byte,
                   input msg_length, input last, output ready);
endinterface

// ===== rtl/websocket_frame_receiver.sv =====
`timescale 1ns / 1ps
// WebSocket frame receiver.
// req_if carries one word per item: op (received byte, connection opened,
// link error) and rx_byte. rsp_if carries at most one word per item: kind,
// msg_type, data_byte, msg_length and last. Both are valid/ready channels.
// csr_wr_en/csr_wr_data write skip_limit; write it only while idle.
// Each accepted word is parsed combinationally by the header/payload logic
// and its result, if any, sits in the output register in the next cycle.
// Throughput is one word per cycle while no result waits on a stalled sink; the output register is the only stage.
// req_if.ready is high while the output register is empty or being taken, so
// a stalled sink holds back the input only once a result is waiting.
// Reset (synchronous, active high) closes the link, returns the parser to the
// first header byte, empties the output register and sets skip_limit to 8192.
// Bytes seen while the link is closed are dropped.

module websocket_frame_receiver
   import wsfr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   wsfr_req_if.sink           req_if,
   wsfr_rsp_if.source         rsp_if,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data
);

   logic [LIMIT_W-1:0] skip_limit_ff;
   logic               link_open_ff, link_open_in;
   pars_type           pars_ff, pars_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic               msg_type_ff, msg_type_in;
   logic [BYTE_W-1:0]  data_ff, data_in;
   logic [MLEN_W-1:0]  mlen_ff, mlen_in;
   logic               last_ff, last_in;

   logic               accept;
   logic               emit;
   logic               len_done;
   logic               hdr_done;
   logic [LIMIT_W-1:0] limit_eff;
   logic [6:0]         len7;
   logic [7:0]         key_byte;
   logic [3:0]         opc_less;

   assign accept     = req_if.valid && req_if.ready;
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign limit_eff  = (skip_limit_ff > LIMIT_CAP) ? LIMIT_CAP : skip_limit_ff;
   assign len7       = req_if.rx_byte[6:0];
   assign opc_less   = pars_ff.opcode - 4'd1;

   always_comb begin
      case (pars_ff.mask_pos)
         2'd0:    key_byte = pars_ff.mask_key[31:24];
         2'd1:    key_byte = pars_ff.mask_key[23:16];
         2'd2:    key_byte = pars_ff.mask_key[15:8];
         default: key_byte = pars_ff.mask_key[7:0];
      endcase
      if (!pars_ff.mask_on) begin
         key_byte = 8'h00;
      end
   end

   always_comb begin
      pars_in      = pars_ff;
      link_open_in = link_open_ff;
      emit         = 1'b0;
      kind_in      = KIND_PAYLOAD;
      msg_type_in  = 1'b0;
      data_in      = '0;
      mlen_in      = '0;
      last_in      = 1'b0;
      len_done     = 1'b0;
      hdr_done     = 1'b0;

      if (accept) begin
         case (req_if.op)
            OP_OPEN: begin
               link_open_in = 1'b1;
               pars_in      = PARS_RESET;
            end
            OP_ERROR: begin
               if (link_open_ff) begin
                  link_open_in = 1'b0;
                  pars_in      = PARS_RESET;
                  emit         = 1'b1;
                  kind_in      = KIND_DISCONN;
               end
            end
            OP_BYTE: begin
               if (link_open_ff) begin
                  case (pars_ff.phase)
                     PH_HDR0: begin
                        pars_in.opcode = req_if.rx_byte[3:0];
                        pars_in.phase  = PH_HDR1;
                     end
                     PH_HDR1: begin
                        pars_in.mask_on     = req_if.rx_byte[7];
                        pars_in.payload_len = '0;
                        if (len7 == LEN_EXT16) begin
                           pars_in.ext_left = EXT16_BYTES;
                           pars_in.phase    = PH_EXT;
                        end else if (len7 == LEN_EXT64) begin
                           pars_in.ext_left = EXT64_BYTES;
                           pars_in.phase    = PH_EXT;
                        end else begin
                           pars_in.payload_len = {{(FLEN_W-7){1'b0}}, len7};
                           len_done            = 1'b1;
                        end
                     end
                     PH_EXT: begin
                        pars_in.payload_len = {pars_ff.payload_len[FLEN_W-9:0],
                                               req_if.rx_byte};
                        if (pars_ff.ext_left != 4'd0) begin
                           pars_in.ext_left = pars_ff.ext_left - 4'd1;
                        end
                        if (pars_in.ext_left == 4'd0) begin
                           len_done = 1'b1;
                        end
                     end
                     PH_KEY: begin
                        pars_in.mask_key = {pars_ff.mask_key[23:0], req_if.rx_byte};
                        if (pars_ff.mask_pos == 2'd3) begin
                           hdr_done = 1'b1;
                        end else begin
                           pars_in.mask_pos = pars_ff.mask_pos + 2'd1;
                        end
                     end
                     PH_DELIVER: begin
                        pars_in.mask_pos  = pars_ff.mask_pos + 2'd1;
                        pars_in.remaining = pars_ff.remaining - 64'd1;
                        emit        = 1'b1;
                        kind_in     = KIND_PAYLOAD;
                        msg_type_in = opc_less[0];
                        data_in     = req_if.rx_byte ^ key_byte;
                        mlen_in     = pars_ff.payload_len[MLEN_W-1:0];
                        if (pars_in.remaining == 64'd0) begin
                           pars_in.phase = PH_HDR0;
                           last_in       = 1'b1;
                        end
                     end
                     PH_DISCARD: begin
                        pars_in.remaining = pars_ff.remaining - 64'd1;
                        if (pars_in.remaining == 64'd0) begin
                           pars_in.phase = PH_HDR0;
                           if (pars_ff.opcode == OPC_PING) begin
                              emit    = 1'b1;
                              kind_in = KIND_SEND_PONG;
                           end else if (pars_ff.opcode == OPC_PONG) begin
                              emit    = 1'b1;
                              kind_in = KIND_PONG_RX;
                           end
                        end
                     end
                     default: begin
                        pars_in = PARS_RESET;
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase
      end

      // end of length field: fetch the mask key or finish the header
      if (len_done) begin
         if (pars_in.mask_on) begin
            pars_in.mask_pos = 2'd0;
            pars_in.mask_key = '0;
            pars_in.phase    = PH_KEY;
         end else begin
            hdr_done = 1'b1;
         end
      end

      if (hdr_done) begin
         pars_in.mask_pos  = 2'd0;
         pars_in.remaining = pars_in.payload_len;
         if (pars_ff.opcode == OPC_CLOSE) begin
            link_open_in = 1'b0;
            pars_in      = PARS_RESET;
            emit         = 1'b1;
            kind_in      = KIND_DISCONN;
         end else if (pars_in.payload_len == 64'd0) begin
            pars_in.phase = PH_HDR0;
            if (pars_ff.opcode == OPC_PING) begin
               emit    = 1'b1;
               kind_in = KIND_SEND_PONG;
            end else if (pars_ff.opcode == OPC_PONG) begin
               emit    = 1'b1;
               kind_in = KIND_PONG_RX;
            end else if (pars_ff.opcode inside {OPC_TEXT, OPC_BINARY}) begin
               emit        = 1'b1;
               kind_in     = KIND_EMPTY;
               msg_type_in = opc_less[0];
               last_in     = 1'b1;
            end
         end else if ((pars_ff.opcode inside {OPC_TEXT, OPC_BINARY}) &&
                      (pars_in.payload_len[FLEN_W-1:LIMIT_W] == '0) &&
                      (pars_in.payload_len[LIMIT_W-1:0] < limit_eff)) begin
            pars_in.phase = PH_DELIVER;
         end else begin
            pars_in.phase = PH_DISCARD;
         end
      end
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_limit_ff <= SKIP_LIMIT_RESET;
         link_open_ff  <= 1'b0;
         pars_ff       <= PARS_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            skip_limit_ff <= csr_wr_data;
         end
         link_open_ff <= link_open_in;
         pars_ff      <= pars_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff     <= kind_in;
         msg_type_ff <= msg_type_in;
         data_ff     <= data_in;
         mlen_ff     <= mlen_in;
         last_ff     <= last_in;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.kind       = kind_ff;
   assign rsp_if.msg_type   = msg_type_ff;
   assign rsp_if.data_byte  = data_ff;
   assign rsp_if.msg_length = mlen_ff;
   assign rsp_if.last       = last_ff;

`ifndef SYNTH
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_if.ready)
      else $error("input stalled with empty output register");

   a_payload_needs_link: assert property (@(posedge clock) disable iff (reset)
      (emit && kind_in == KIND_PAYLOAD) |-> link_open_ff)
      else $error("payload word produced while link closed");

   a_disconn_closes: assert property (@(posedge clock) disable iff (reset)
      (emit && kind_in == KIND_DISCONN) |=> !link_open_ff)
      else $error("link still open after disconnect");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (emit && kind_in == KIND_EMPTY) |-> last_in)
      else $error("empty message without last mark");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import wsfr_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS = 250;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [BYTE_W-1:0] rx_byte;
   } rx_item_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              msg_type;
      logic [BYTE_W-1:0] data_byte;
      logic [MLEN_W-1:0] msg_length;
      logic              last;
   } rsp_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0] csr_wr_data = '0;

   wsfr_req_if req_bus ();
   wsfr_rsp_if rsp_bus ();

   websocket_frame_receiver dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   rx_item_type  rx_stream_q[$];
   rsp_word_type due_words[$];
   int        queued_items = 0;
   int        errors = 0;
   int        quiet_cycles = 0;
   bit        req_taken = 1'b0;
   bit        calm = 1'b0;
   bit        rx_hold = 1'b0;
   bit        pressure_go = 1'b0;
   bit        link_guess = 1'b0;

   // parser state as seen by the checker
   bit                 m_open = 1'b0;
   phase_type          m_phase = PH_HDR0;
   logic [3:0]         m_opc = 4'h0;
   logic               m_masked = 1'b0;
   logic [3:0]         m_ext_left = 4'h0;
   logic [31:0]        m_key = 32'h0;
   logic [1:0]         m_key_pos = 2'd0;
   logic [63:0]        m_remaining = 64'd0;
   logic [63:0]        m_payload_len = 64'd0;
   logic [LIMIT_W-1:0] m_skip_limit = SKIP_LIMIT_RESET;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void restart_frame();
      m_phase       = PH_HDR0;
      m_opc         = 4'h0;
      m_masked      = 1'b0;
      m_ext_left    = 4'h0;
      m_key         = 32'h0;
      m_key_pos     = 2'd0;
      m_remaining   = 64'd0;
      m_payload_len = 64'd0;
   endfunction

   // ping and pong report once their payload is gone
   function automatic bit control_word(output rsp_word_type w);
      w = '0;
      if (m_opc == OPC_PING) begin
         w.kind = KIND_SEND_PONG;
         return 1'b1;
      end
      if (m_opc == OPC_PONG) begin
         w.kind = KIND_PONG_RX;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit finish_header(output rsp_word_type w);
      logic [LIMIT_W-1:0] cap;
      cap = (m_skip_limit > LIMIT_CAP) ? LIMIT_CAP : m_skip_limit;
      w = '0;
      m_key_pos   = 2'd0;
      m_remaining = m_payload_len;
      if (m_opc == OPC_CLOSE) begin
         m_open = 1'b0;
         restart_frame();
         w.kind = KIND_DISCONN;
         return 1'b1;
      end
      if (m_payload_len == 64'd0) begin
         m_phase = PH_HDR0;
         if (m_opc == OPC_TEXT || m_opc == OPC_BINARY) begin
            w.kind     = KIND_EMPTY;
            w.msg_type = (m_opc == OPC_BINARY);
            w.last     = 1'b1;
            return 1'b1;
         end
         return control_word(w);
      end
      if ((m_opc == OPC_TEXT || m_opc == OPC_BINARY) && m_payload_len < 64'(cap))
         m_phase = PH_DELIVER;
      else
         m_phase = PH_DISCARD;
      return 1'b0;
   endfunction

   function automatic bit finish_length(output rsp_word_type w);
      w = '0;
      if (m_masked) begin
         m_key_pos = 2'd0;
         m_key     = 32'h0;
         m_phase   = PH_KEY;
         return 1'b0;
      end
      return finish_header(w);
   endfunction

   function automatic bit advance_parser(input logic [OP_W-1:0] op,
                                         input logic [BYTE_W-1:0] b,
                                         output rsp_word_type w);
      logic [7:0] key_byte;
      logic [6:0] len7;
      w = '0;
      case (op)
         OP_OPEN: begin
            m_open = 1'b1;
            restart_frame();
            return 1'b0;
         end
         OP_ERROR: begin
            if (!m_open)
               return 1'b0;
            m_open = 1'b0;
            restart_frame();
            w.kind = KIND_DISCONN;
            return 1'b1;
         end
         OP_BYTE: begin
            if (!m_open)
               return 1'b0;
            case (m_phase)
               PH_HDR0: begin
                  m_opc   = b[3:0];
                  m_phase = PH_HDR1;
               end
               PH_HDR1: begin
                  m_masked      = b[7];
                  len7          = b[6:0];
                  m_payload_len = 64'd0;
                  if (len7 == LEN_EXT16) begin
                     m_ext_left = EXT16_BYTES;
                     m_phase    = PH_EXT;
                  end else if (len7 == LEN_EXT64) begin
                     m_ext_left = EXT64_BYTES;
                     m_phase    = PH_EXT;
                  end else begin
                     m_payload_len = 64'(len7);
                     return finish_length(w);
                  end
               end
               PH_EXT: begin
                  m_payload_len = {m_payload_len[55:0], b};
                  if (m_ext_left != 4'h0)
                     m_ext_left--;
                  if (m_ext_left == 4'h0)
                     return finish_length(w);
               end
               PH_KEY: begin
                  m_key = {m_key[23:0], b};
                  if (m_key_pos == 2'd3)
                     return finish_header(w);
                  m_key_pos++;
               end
               PH_DELIVER: begin
                  key_byte = m_masked ? m_key[8*(3-m_key_pos) +: 8] : 8'h00;
                  m_key_pos++;
                  m_remaining--;
                  w.kind       = KIND_PAYLOAD;
                  w.msg_type   = (m_opc == OPC_BINARY);
                  w.data_byte  = b ^ key_byte;
                  w.msg_length = m_payload_len[15:0];
                  w.last       = (m_remaining == 64'd0);
                  if (m_remaining == 64'd0)
                     m_phase = PH_HDR0;
                  return 1'b1;
               end
               PH_DISCARD: begin
                  m_remaining--;
                  if (m_remaining != 64'd0)
                     return 1'b0;
                  m_phase = PH_HDR0;
                  return control_word(w);
               end
               default: restart_frame();
            endcase
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   function automatic void push_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b);
      rx_stream_q.push_back({op, b});
      queued_items++;
   endfunction

   // form: 0 seven-bit length, 1 16-bit extension, 2 64-bit extension
   function automatic void queue_frame(input logic [3:0] opc, input logic [63:0] len,
                                       input bit masked, input int form, input int sent);
      logic [31:0] key;
      int          n;
      key = $urandom;
      push_item(OP_BYTE, {4'($urandom), opc});
      case (form)
         0: push_item(OP_BYTE, {masked, len[6:0]});
         1: begin
            push_item(OP_BYTE, {masked, LEN_EXT16});
            push_item(OP_BYTE, len[15:8]);
            push_item(OP_BYTE, len[7:0]);
         end
         default: begin
            push_item(OP_BYTE, {masked, LEN_EXT64});
            for (int i = 7; i >= 0; i--)
               push_item(OP_BYTE, len[8*i +: 8]);
         end
      endcase
      if (masked)
         for (int i = 3; i >= 0; i--)
            push_item(OP_BYTE, key[8*i +: 8]);
      n = (len > 64'(sent)) ? sent : int'(len);
      for (int i = 0; i < n; i++)
         push_item(OP_BYTE, 8'($urandom));
   endfunction

   task automatic queue_random_traffic(input int budget, input int unsigned lim);
      int               target;
      int               pick;
      int               len;
      int               form;
      logic [3:0]       opc;
      logic [OP_W-1:0]  opn;
      target = queued_items + budget;
      while (queued_items < target) begin
         if (!link_guess) begin
            push_item(OP_OPEN, 8'($urandom));
            link_guess = 1'b1;
         end
         pick = $urandom_range(99, 0);
         if (pick < 8) begin
            // stray words, then resync with a fresh open
            repeat ($urandom_range(3, 1)) begin
               opn = 2'($urandom);
               push_item(opn, 8'($urandom));
            end
            push_item(OP_OPEN, 8'($urandom));
         end else if (pick < 14) begin
            if ($urandom_range(1, 0) != 0) begin
               push_item(OP_BYTE, 8'($urandom));
               push_item(OP_BYTE, 8'($urandom));
            end else begin
               queue_frame(4'($urandom), {$urandom, $urandom}, 1'($urandom), 2,
                           $urandom_range(4, 0));
            end
            if ($urandom_range(1, 0) != 0) begin
               push_item(OP_OPEN, 8'($urandom));
            end else begin
               push_item(OP_ERROR, 8'($urandom));
               link_guess = 1'b0;
            end
         end else begin
            pick = $urandom_range(99, 0);
            if (pick < 55)
               opc = ($urandom_range(1, 0) != 0) ? OPC_BINARY : OPC_TEXT;
            else if (pick < 65)
               opc = OPC_PING;
            else if (pick < 75)
               opc = OPC_PONG;
            else if (pick < 80)
               opc = OPC_CLOSE;
            else
               opc = 4'($urandom);
            pick = $urandom_range(99, 0);
            form = 0;
            if (pick < 60) begin
               len = $urandom_range(12, 0);
            end else if (pick < 70) begin
               len  = $urandom_range(300, 0);
               form = 1;
            end else if (pick < 78) begin
               len  = $urandom_range(30, 0);
               form = 2;
            end else if (pick < 90 && lim <= 400) begin
               // either side of the skip threshold
               len  = (lim == 0) ? 0 : int'(lim) - int'($urandom_range(1, 0));
               form = (len < 126 && $urandom_range(1, 0) != 0) ? 0 : 1;
            end else begin
               len = $urandom_range(125, 0);
            end
            queue_frame(opc, 64'(len), 1'($urandom), form, len);
            if (opc == OPC_CLOSE)
               link_guess = 1'b0;
         end
      end
   endtask

   task automatic wait_until_quiet();
      while (rx_stream_q.size() != 0 || req_bus.valid || due_words.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   function automatic void compare_field(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h got %0h", $time, name, want, got);
      end
   endfunction

   always @(negedge clock) begin : drive_words
      rx_item_type item;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (rx_stream_q.size() != 0 && (calm || $urandom_range(99, 0) >= 25)) begin
            item = rx_stream_q.pop_front();
            req_bus.valid   <= 1'b1;
            req_bus.op      <= item.op;
            req_bus.rx_byte <= item.rx_byte;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : drive_ready
      if (reset || rx_hold) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= calm || $urandom_range(99, 0) >= 25;
      end
   end

   always @(posedge clock) begin : observe
      rsp_word_type got;
      rsp_word_type want;
      rsp_word_type pred;
      req_taken = 1'b0;
      if (!reset) begin
         quiet_cycles++;
         if (csr_wr_en)
            m_skip_limit = csr_wr_data;
         if (rsp_bus.valid && rsp_bus.ready) begin
            quiet_cycles = 0;
            got = {rsp_bus.kind, rsp_bus.msg_type, rsp_bus.data_byte, rsp_bus.msg_length,
                   rsp_bus.last};
            if (due_words.size() == 0) begin
               errors++;
               $display("%0t: unexpected word, expected none, got kind %0d data %02h",
                        $time, got.kind, got.data_byte);
            end else begin
               want = due_words.pop_front();
               compare_field("kind", 16'(want.kind), 16'(got.kind));
               compare_field("msg_type", 16'(want.msg_type), 16'(got.msg_type));
               compare_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
               compare_field("msg_length", want.msg_length, got.msg_length);
               compare_field("last", 16'(want.last), 16'(got.last));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            quiet_cycles = 0;
            req_taken    = 1'b1;
            if (advance_parser(req_bus.op, req_bus.rx_byte, pred))
               due_words.push_back(pred);
         end
      end
   end

   initial begin : watchdog
      @(negedge clock);
      while (quiet_cycles < STALL_LIMIT)
         @(negedge clock);
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("FAILURE");
      $finish;
   end

   // long receiver stall while the sender keeps offering words
   initial begin : receiver_holdoff
      wait (pressure_go);
      repeat (40) @(posedge clock);
      rx_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rx_hold = 1'b0;
   end

   initial begin : stimulus
      int unsigned skip_settings[6];
      skip_settings   = '{0, 1, 17, 300, 65536, 131071};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push_item(OP_BYTE, 8'h55);
      push_item(OP_ERROR, 8'hFF);
      push_item(OP_UNUSED, 8'h00);
      push_item(OP_OPEN, 8'h00);
      push_item(OP_BYTE, {4'h8, OPC_TEXT});
      push_item(OP_BYTE, 8'h00);
      push_item(OP_BYTE, {4'h8, OPC_BINARY});
      push_item(OP_BYTE, 8'h81);
      push_item(OP_BYTE, 8'hFF);
      push_item(OP_BYTE, 8'h00);
      push_item(OP_BYTE, 8'hA5);
      push_item(OP_BYTE, 8'h5A);
      push_item(OP_BYTE, 8'h0F);
      push_item(OP_BYTE, {4'h8, OPC_PING});
      push_item(OP_BYTE, 8'h00);
      push_item(OP_BYTE, {4'h8, OPC_PONG});
      push_item(OP_BYTE, 8'h01);
      push_item(OP_BYTE, 8'h33);
      push_item(OP_BYTE, {4'h8, OPC_CLOSE});
      push_item(OP_BYTE, 8'h00);
      push_item(OP_OPEN, 8'hFF);
      push_item(OP_BYTE, 8'hFF);
      push_item(OP_ERROR, 8'h00);
      wait_until_quiet();

      pressure_go = 1'b1;
      queue_random_traffic(PHASE_ITEMS, SKIP_LIMIT_RESET);
      wait_until_quiet();

      foreach (skip_settings[i]) begin
         calm = (i == 3);
         @(negedge clock);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= LIMIT_W'(skip_settings[i]);
         @(negedge clock);
         csr_wr_en   <= 1'b0;
         @(posedge clock);
         queue_random_traffic(PHASE_ITEMS, skip_settings[i]);
         wait_until_quiet();
      end

      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
